/* sv/pcr_pkg.sv */
// Shared types, codes and constants for the positioner command responder.
`timescale 1ns / 1ps

package pcr_pkg;

   // Event kinds carried in the mode field
   localparam logic [2:0] MODE_FRAME     = 3'd0;
   localparam logic [2:0] MODE_MOVE_DONE = 3'd1;
   localparam logic [2:0] MODE_LINK      = 3'd2;
   localparam logic [2:0] MODE_SET_XYZ   = 3'd3;
   localparam logic [2:0] MODE_LATERAL   = 3'd4;

   // Frame command codes
   localparam logic [7:0] CMD_SYSTEM  = 8'h8D;
   localparam logic [7:0] CMD_GET_X   = 8'h8E;
   localparam logic [7:0] CMD_GET_Y   = 8'h8F;
   localparam logic [7:0] CMD_GET_Z   = 8'h90;
   localparam logic [7:0] CMD_SET_X   = 8'hCE;
   localparam logic [7:0] CMD_SET_Y   = 8'hCF;
   localparam logic [7:0] CMD_SET_Z   = 8'hD0;
   localparam logic [7:0] CMD_MOVE    = 8'h10;

   // Subcommands
   localparam logic [7:0] SUB_STATUS_CLR = 8'd0;
   localparam logic [7:0] SUB_REVISION   = 8'd3;
   localparam logic [7:0] SUB_CHECKSUM   = 8'd4;
   localparam logic [7:0] SUB_NEEDLE     = 8'd5;
   localparam logic [7:0] SUB_STATUS     = 8'd6;
   localparam logic [7:0] SUB_POSITION   = 8'd0;
   localparam logic [7:0] SUB_TARGET     = 8'd1;
   localparam logic [7:0] SUB_SHUTTLE    = 8'd2;
   localparam logic [7:0] SUB_MOVE_XYZ   = 8'd0;
   localparam logic [7:0] SUB_MOVE_STEP  = 8'd2;
   localparam logic [7:0] ARG_CLEAR      = 8'd1;

   // Reply and status constants
   localparam logic [7:0]  REVISION       = 8'h01;
   localparam logic [7:0]  CHECKSUM_LOW   = 8'hAA;
   localparam logic [7:0]  CHECKSUM_HIGH  = 8'hBB;
   localparam logic [7:0]  STAT_LOW_RST   = 8'h42;
   localparam logic [7:0]  STAT_HIGH_RST  = 8'h80;
   localparam logic [7:0]  STAT_LOW_MASK  = 8'h3F;
   localparam logic [7:0]  STAT_HIGH_MASK = 8'h7F;
   localparam logic [7:0]  STAT_MOVING    = 8'h01;
   localparam logic [7:0]  STAT_DONE      = 8'h40;
   localparam logic [7:0]  STAT_HOME      = 8'h04;
   localparam logic [7:0]  STAT_AT_TARGET = 8'h02;
   localparam logic [15:0] HOME_X_MID     = 16'd1290;
   localparam logic [15:0] HOME_X_FAR     = 16'd2580;
   localparam logic [15:0] STEP_Z_LIMIT   = 16'd1300;
   localparam logic [15:0] STEP_Z_INC     = 16'd10;

   // Configuration register indexes
   localparam logic CSR_NEEDLE  = 1'b0;
   localparam logic CSR_SHUTTLE = 1'b1;

   typedef enum logic [1:0] {
      PEND_NONE      = 2'd0,
      PEND_XYZ       = 2'd1,
      PEND_STEP_DOWN = 2'd2
   } pend_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  cmd_byte;
      logic [7:0]  sub_byte;
      logic [7:0]  arg_byte;
      logic        link_up;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
      logic [1:0]  lateral;
   } req_type;

   typedef struct packed {
      logic [7:0] reply_code;
      logic [7:0] reply_low;
      logic [7:0] reply_high;
      logic [7:0] reply_check;
      logic       reply_valid;
   } rsp_type;

   // Engine state seen by the top level
   typedef struct packed {
      logic     connected;
      logic     moving;
      pend_type pending_move;
   } eng_status_type;

endpackage

/* sv/pcr_engine.sv */
// Positioner state registers and the single-pass request decode.
`timescale 1ns / 1ps

module pcr_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  pcr_pkg::req_type        item,
   input  logic [15:0]             needle_level,
   input  logic [15:0]             shuttle_height,
   output pcr_pkg::rsp_type        reply,
   output pcr_pkg::eng_status_type status
);
   import pcr_pkg::*;

   logic        connected_ff, connected_in;
   logic        moving_ff, moving_in;
   pend_type    pending_ff, pending_in;
   logic [7:0]  stat_low_ff, stat_low_in;
   logic [7:0]  stat_high_ff, stat_high_in;
   logic [15:0] pos_ff [3];
   logic [15:0] pos_in [3];
   logic [15:0] tgt_ff [3];
   logic [15:0] tgt_in [3];

   logic [7:0]  ax_diff;
   logic [1:0]  ax;
   logic [15:0] z_step;
   logic [15:0] word_val;
   logic        known;
   logic        word;
   logic [7:0]  r_low;
   logic [7:0]  r_high;
   logic        home;

   function automatic logic [15:0] pick_axis(input logic [15:0] a0, input logic [15:0] a1,
                                             input logic [15:0] a2, input logic [1:0] sel);
      logic [15:0] v;
      case (sel)
         2'd0:    v = a0;
         2'd1:    v = a1;
         default: v = a2;
      endcase
      return v;
   endfunction

   // GET and SET groups share low bits: 8E/CE -> 0, 8F/CF -> 1, 90/D0 -> 2
   assign ax_diff = item.cmd_byte - ((item.cmd_byte[6]) ? CMD_SET_X : CMD_GET_X);
   assign ax      = ax_diff[1:0];

   assign z_step = (tgt_ff[2] > STEP_Z_LIMIT) ? STEP_Z_LIMIT : tgt_ff[2] + STEP_Z_INC;

   always_comb begin
      connected_in = connected_ff;
      moving_in    = moving_ff;
      pending_in   = pending_ff;
      stat_low_in  = stat_low_ff;
      stat_high_in = stat_high_ff;
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
         tgt_in[i] = tgt_ff[i];
      end
      known    = 1'b0;
      word     = 1'b0;
      word_val = '0;
      r_low    = '0;
      r_high   = '0;
      home     = 1'b0;
      reply    = '0;

      unique case (item.mode)
         MODE_FRAME: begin
            reply.reply_valid = 1'b1;
            if (connected_ff && !moving_ff) begin
               known = 1'b1;
               unique case (item.cmd_byte)
                  CMD_SYSTEM: begin
                     unique case (item.sub_byte)
                        SUB_STATUS_CLR: begin
                           r_low  = stat_low_ff;
                           r_high = stat_high_ff;
                           if (item.arg_byte == ARG_CLEAR) begin
                              stat_low_in  = stat_low_ff & STAT_LOW_MASK;
                              stat_high_in = stat_high_ff & STAT_HIGH_MASK;
                           end
                        end
                        SUB_REVISION: begin
                           r_low = REVISION;
                        end
                        SUB_CHECKSUM: begin
                           r_low  = CHECKSUM_LOW;
                           r_high = CHECKSUM_HIGH;
                        end
                        SUB_NEEDLE: begin
                           word     = 1'b1;
                           word_val = needle_level;
                        end
                        SUB_STATUS: begin
                           r_low  = stat_low_ff;
                           r_high = stat_high_ff;
                        end
                        default: known = 1'b0;
                     endcase
                  end
                  CMD_GET_X, CMD_GET_Y, CMD_GET_Z: begin
                     word = 1'b1;
                     if (item.sub_byte == SUB_POSITION) begin
                        word_val = pick_axis(pos_ff[0], pos_ff[1], pos_ff[2], ax);
                     end else if (item.sub_byte == SUB_TARGET) begin
                        word_val = pick_axis(tgt_ff[0], tgt_ff[1], tgt_ff[2], ax);
                     end else if (item.sub_byte == SUB_SHUTTLE && item.cmd_byte == CMD_GET_Z) begin
                        word_val = shuttle_height;
                     end else begin
                        known = 1'b0;
                     end
                  end
                  CMD_SET_X, CMD_SET_Y, CMD_SET_Z: begin
                     word     = 1'b1;
                     word_val = {item.arg_byte, item.sub_byte};
                     for (int i = 0; i < 3; i++) begin
                        if (ax == 2'(i)) tgt_in[i] = word_val;
                     end
                  end
                  CMD_MOVE: begin
                     if (item.sub_byte == SUB_MOVE_XYZ || item.sub_byte == SUB_MOVE_STEP) begin
                        stat_low_in = STAT_MOVING;
                        moving_in   = 1'b1;
                        pending_in  = (item.sub_byte == SUB_MOVE_XYZ) ? PEND_XYZ
                                                                      : PEND_STEP_DOWN;
                        r_low       = STAT_MOVING;
                        r_high      = stat_high_ff;
                     end else begin
                        known = 1'b0;
                     end
                  end
                  default: known = 1'b0;
               endcase
            end
            if (known) begin
               if (word) begin
                  r_low  = word_val[7:0];
                  r_high = word_val[15:8];
               end
               reply.reply_code  = item.cmd_byte;
               reply.reply_low   = r_low;
               reply.reply_high  = r_high;
               reply.reply_check = item.cmd_byte ^ r_low ^ r_high;
            end
         end
         MODE_MOVE_DONE: begin
            if (connected_ff && pending_ff != PEND_NONE) begin
               if (pending_ff == PEND_STEP_DOWN) tgt_in[2] = z_step;
               for (int i = 0; i < 3; i++) pos_in[i] = tgt_in[i];
               home = (tgt_in[0] == '0 || tgt_in[0] == HOME_X_FAR || tgt_in[0] == HOME_X_MID)
                      && tgt_in[1] == '0 && tgt_in[2] == '0;
               stat_low_in = STAT_DONE | (home ? STAT_HOME : STAT_AT_TARGET);
               moving_in   = 1'b0;
               pending_in  = PEND_NONE;
            end
         end
         MODE_LINK: begin
            connected_in = item.link_up;
            if (item.link_up && !connected_ff) begin
               moving_in    = 1'b0;
               stat_low_in  = STAT_LOW_RST;
               stat_high_in = STAT_HIGH_RST;
               for (int i = 0; i < 3; i++) pos_in[i] = '0;
            end
         end
         MODE_SET_XYZ: begin
            pos_in[0] = item.pos_x;
            pos_in[1] = item.pos_y;
            pos_in[2] = item.pos_z;
            tgt_in[0] = item.pos_x;
            tgt_in[1] = item.pos_y;
            tgt_in[2] = item.pos_z;
         end
         MODE_LATERAL: begin
            stat_high_in = {stat_high_ff[7:2], item.lateral};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
         moving_ff    <= 1'b0;
         pending_ff   <= PEND_NONE;
         stat_low_ff  <= STAT_LOW_RST;
         stat_high_ff <= STAT_HIGH_RST;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
      end else if (fire) begin
         connected_ff <= connected_in;
         moving_ff    <= moving_in;
         pending_ff   <= pending_in;
         stat_low_ff  <= stat_low_in;
         stat_high_ff <= stat_high_in;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_in[i];
            tgt_ff[i] <= tgt_in[i];
         end
      end
   end

   assign status.connected    = connected_ff;
   assign status.moving       = moving_ff;
   assign status.pending_move = pending_ff;

endmodule

/* sv/positioner_command_responder.sv */
// Top level: request register, positioner engine, reply register and config registers.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  req     | in        | req_valid/req_ready  | req_data  (pcr_pkg::req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (pcr_pkg::rsp_type)
//  csr     | in        | csr_valid/csr_ready  | csr_index (1 bit), csr_data (16 bit)
//
// One request per cycle while rsp_ready is high; rsp_valid rises as a request passes
// the request register, then decode and state update into the reply register.
// Every request gives exactly one reply, including non-frame events.
// Reset is synchronous: positioner state returns to its power-up values, both
// pipeline registers empty, config registers clear.
// A stalled reply holds the pipe; req_ready stays high while the request register
// is empty or moving forward, so no bubble is inserted under a steady rsp_ready.
// csr writes are always taken: csr_ready is held high.
`timescale 1ns / 1ps

module positioner_command_responder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_data
);
   import pcr_pkg::*;

   // Request stage
   logic           in_valid_ff, in_valid_in;
   req_type        in_data_ff;
   // Reply stage
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_data_ff;
   // Config registers
   logic [15:0]    needle_ff;
   logic [15:0]    shuttle_ff;

   logic           advance;
   rsp_type        reply;
   eng_status_type eng_status;

   // Request moves into the reply register when that register is free or drains now
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= reply;
      end
   end

   // Config writes: host must write only while no request is in flight; not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff  <= '0;
         shuttle_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NEEDLE:  needle_ff  <= csr_data;
            CSR_SHUTTLE: shuttle_ff <= csr_data;
            default: ;
         endcase
      end
   end

   pcr_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .item           (in_data_ff),
      .needle_level   (needle_ff),
      .shuttle_height (shuttle_ff),
      .reply          (reply),
      .status         (eng_status)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A running move always has a pending command behind it
   a_moving_pending: assert property (@(posedge clock) disable iff (reset)
      eng_status.moving |-> eng_status.pending_move != PEND_NONE)
      else $error("moving set with no pending move");

   // Check byte always matches the three reply bytes
   a_check_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.reply_check ==
                    (rsp_data.reply_code ^ rsp_data.reply_low ^ rsp_data.reply_high))
      else $error("reply check byte mismatch");

   // Non-frame events reply with all zero bytes
   a_event_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.reply_valid) |->
         (rsp_data.reply_code == '0 && rsp_data.reply_low == '0 &&
          rsp_data.reply_high == '0))
      else $error("non-frame reply carries data");

   // A stalled reply keeps the request stage from advancing
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !advance)
      else $error("pipe advanced into a stalled reply");

endmodule

/* verif/tb_positioner_command_responder.sv */
// Testbench for positioner_command_responder: scripted and random events checked against a built-in state model.
`timescale 1ns / 1ps

module tb_positioner_command_responder;
   import pcr_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int CYCLE_LIMIT = 200000;   // watchdog limit; normal runs finish well inside it
   localparam int HOLD_CYCLES = 150;      // long receiver hold-off in the backpressure test
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ITEMS = 400;

   // Spare event modes: accepted and answered, but change nothing
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT inputs (all start at known values)
   // ---------------------------------------------------------------------------
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_NEEDLE;
   logic [15:0] csr_data  = '0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   positioner_command_responder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Positioner model state: mirrors the block from reset onward
   // ---------------------------------------------------------------------------
   logic        link_on   = 1'b0;
   logic        busy      = 1'b0;
   pend_type    pend_move = PEND_NONE;
   logic [7:0]  stat_lo   = STAT_LOW_RST;
   logic [7:0]  stat_hi   = STAT_HIGH_RST;
   logic [15:0] axis_pos [3] = '{default: '0};
   logic [15:0] axis_tgt [3] = '{default: '0};
   logic [15:0] needle_reg  = '0;
   logic [15:0] shuttle_reg = '0;

   // Replies still owed by the block, oldest first
   rsp_type expected_replies [$];

   // Traffic shaping, written only by the test sequence
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;

   // Receiver-side bookkeeping
   int hold_served = 0;
   int hold_left   = 0;

   // Run statistics
   int cycle_count    = 0;
   int mismatch_count = 0;
   int request_count  = 0;
   int reply_count    = 0;
   int frames_served  = 0;
   int moves_finished = 0;
   int config_writes  = 0;

   // ---------------------------------------------------------------------------
   // Model: apply one accepted request, return the reply it must produce
   // ---------------------------------------------------------------------------
   function automatic rsp_type advance_positioner(input req_type r);
      rsp_type     rsp;
      logic [15:0] word_val;
      logic        known;
      logic        as_word;
      int          ax;
      int          i;
      rsp      = '0;
      word_val = '0;
      known    = 1'b1;
      as_word  = 1'b1;
      ax       = 0;
      case (r.mode)
         MODE_FRAME: begin
            rsp.reply_valid = 1'b1;
            // busy or offline: zero reply bytes, no state change
            if (link_on && !busy) begin
               case (r.cmd_byte)
                  CMD_SYSTEM: begin
                     as_word = 1'b0;
                     case (r.sub_byte)
                        SUB_STATUS_CLR: begin
                           // reply carries the bytes from before the clear
                           rsp.reply_low  = stat_lo;
                           rsp.reply_high = stat_hi;
                           if (r.arg_byte == ARG_CLEAR) begin
                              stat_lo &= STAT_LOW_MASK;
                              stat_hi &= STAT_HIGH_MASK;
                           end
                        end
                        SUB_REVISION: begin
                           rsp.reply_low = REVISION;
                        end
                        SUB_CHECKSUM: begin
                           rsp.reply_low  = CHECKSUM_LOW;
                           rsp.reply_high = CHECKSUM_HIGH;
                        end
                        SUB_NEEDLE: begin
                           as_word  = 1'b1;
                           word_val = needle_reg;
                        end
                        SUB_STATUS: begin
                           rsp.reply_low  = stat_lo;
                           rsp.reply_high = stat_hi;
                        end
                        default: known = 1'b0;
                     endcase
                  end
                  CMD_GET_X, CMD_GET_Y, CMD_GET_Z: begin
                     ax = int'(r.cmd_byte - CMD_GET_X);
                     if (r.sub_byte == SUB_POSITION)
                        word_val = axis_pos[ax];
                     else if (r.sub_byte == SUB_TARGET)
                        word_val = axis_tgt[ax];
                     else if (r.sub_byte == SUB_SHUTTLE && r.cmd_byte == CMD_GET_Z)
                        word_val = shuttle_reg;
                     else
                        known = 1'b0;
                  end
                  CMD_SET_X, CMD_SET_Y, CMD_SET_Z: begin
                     ax = int'(r.cmd_byte - CMD_SET_X);
                     axis_tgt[ax] = {r.arg_byte, r.sub_byte};
                     word_val     = axis_tgt[ax];
                  end
                  CMD_MOVE: begin
                     if (r.sub_byte == SUB_MOVE_XYZ || r.sub_byte == SUB_MOVE_STEP) begin
                        as_word = 1'b0;
                        stat_lo = STAT_MOVING;
                        if (r.sub_byte == SUB_MOVE_XYZ)
                           pend_move = PEND_XYZ;
                        else
                           pend_move = PEND_STEP_DOWN;
                        busy           = 1'b1;
                        rsp.reply_low  = stat_lo;
                        rsp.reply_high = stat_hi;
                     end else begin
                        known = 1'b0;
                     end
                  end
                  default: known = 1'b0;
               endcase
               if (!known) begin
                  rsp.reply_low  = '0;
                  rsp.reply_high = '0;
               end else begin
                  rsp.reply_code = r.cmd_byte;
                  if (as_word) begin
                     rsp.reply_low  = word_val[7:0];
                     rsp.reply_high = word_val[15:8];
                  end
                  rsp.reply_check = rsp.reply_code ^ rsp.reply_low ^ rsp.reply_high;
                  frames_served++;
               end
            end
         end
         MODE_MOVE_DONE: begin
            if (link_on && pend_move != PEND_NONE) begin
               // step down: clamp Z target to the limit, or creep up by one step
               if (pend_move == PEND_STEP_DOWN) begin
                  if (axis_tgt[2] > STEP_Z_LIMIT)
                     axis_tgt[2] = STEP_Z_LIMIT;
                  else
                     axis_tgt[2] = axis_tgt[2] + STEP_Z_INC;
               end
               for (i = 0; i < 3; i++)
                  axis_pos[i] = axis_tgt[i];
               if ((axis_pos[0] == '0 || axis_pos[0] == HOME_X_MID || axis_pos[0] == HOME_X_FAR)
                   && axis_pos[1] == '0 && axis_pos[2] == '0)
                  stat_lo = STAT_DONE | STAT_HOME;
               else
                  stat_lo = STAT_DONE | STAT_AT_TARGET;
               busy      = 1'b0;
               pend_move = PEND_NONE;
               moves_finished++;
            end
         end
         MODE_LINK: begin
            if (r.link_up) begin
               // only a rising connection resets status and positions
               if (!link_on) begin
                  busy    = 1'b0;
                  stat_lo = STAT_LOW_RST;
                  stat_hi = STAT_HIGH_RST;
                  for (i = 0; i < 3; i++)
                     axis_pos[i] = '0;
               end
               link_on = 1'b1;
            end else begin
               link_on = 1'b0;
            end
         end
         MODE_SET_XYZ: begin
            axis_pos[0] = r.pos_x;
            axis_pos[1] = r.pos_y;
            axis_pos[2] = r.pos_z;
            for (i = 0; i < 3; i++)
               axis_tgt[i] = axis_pos[i];
         end
         MODE_LATERAL: begin
            stat_hi = {stat_hi[7:2], r.lateral};
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // ---------------------------------------------------------------------------
   // Request monitor and reply checker: one process, push before pop so a
   // request accepted at the same edge is already queued
   // ---------------------------------------------------------------------------
   task automatic note_failure(input rsp_type want, input logic have_want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         if (have_want)
            $display("reply %0d mismatch: expected code %02h low %02h high %02h check %02h valid %0b, got code %02h low %02h high %02h check %02h valid %0b",
                     reply_count, want.reply_code, want.reply_low, want.reply_high,
                     want.reply_check, want.reply_valid, rsp_data.reply_code,
                     rsp_data.reply_low, rsp_data.reply_high, rsp_data.reply_check,
                     rsp_data.reply_valid);
         else
            $display("reply %0d with nothing outstanding: code %02h low %02h high %02h check %02h valid %0b",
                     reply_count, rsp_data.reply_code, rsp_data.reply_low,
                     rsp_data.reply_high, rsp_data.reply_check, rsp_data.reply_valid);
      end
   endtask

   always @(posedge clock) begin : track_replies
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_replies.push_back(advance_positioner(req_data));
            request_count++;
         end
         if (rsp_valid && rsp_ready) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
               note_failure('0, 1'b0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.reply_code  !== want.reply_code  ||
                   rsp_data.reply_low   !== want.reply_low   ||
                   rsp_data.reply_high  !== want.reply_high  ||
                   rsp_data.reply_check !== want.reply_check ||
                   rsp_data.reply_valid !== want.reply_valid)
                  note_failure(want, 1'b1);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request from the tests
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, expected_replies.size());
         $display("positioner_command_responder regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------------
   function automatic req_type blank_request(input logic [2:0] mode);
      req_type r;
      r      = '0;
      r.mode = mode;
      return r;
   endfunction

   // Mostly well-formed traffic: frames the block knows, moves and completion
   // ticks, some reconnects; the rest is noise.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.mode     = MODE_FRAME;
      r.cmd_byte = 8'($urandom);
      r.sub_byte = 8'($urandom);
      r.arg_byte = 8'($urandom);
      r.link_up  = 1'($urandom);
      r.pos_x    = 16'($urandom);
      r.pos_y    = 16'($urandom);
      r.pos_z    = 16'($urandom);
      r.lateral  = 2'($urandom);
      pick       = $urandom_range(99);
      if (pick < 55) begin
         case ($urandom_range(15))
            0, 1, 2, 3: begin
               r.cmd_byte = CMD_SYSTEM;
               case ($urandom_range(5))
                  0: r.sub_byte = SUB_STATUS_CLR;
                  1: r.sub_byte = SUB_REVISION;
                  2: r.sub_byte = SUB_CHECKSUM;
                  3: r.sub_byte = SUB_NEEDLE;
                  4: r.sub_byte = SUB_STATUS;
                  default: ;
               endcase
               if ($urandom_range(1) == 0)
                  r.arg_byte = ARG_CLEAR;
            end
            4, 5, 6: begin
               case ($urandom_range(2))
                  0: r.cmd_byte = CMD_GET_X;
                  1: r.cmd_byte = CMD_GET_Y;
                  default: r.cmd_byte = CMD_GET_Z;
               endcase
               case ($urandom_range(4))
                  0: r.sub_byte = SUB_POSITION;
                  1: r.sub_byte = SUB_TARGET;
                  2, 3: r.sub_byte = SUB_SHUTTLE;
                  default: ;
               endcase
            end
            7, 8, 9: begin
               case ($urandom_range(2))
                  0: r.cmd_byte = CMD_SET_X;
                  1: r.cmd_byte = CMD_SET_Y;
                  default: r.cmd_byte = CMD_SET_Z;
               endcase
               // Z targets around the step-down limit, and home-ish values
               if ($urandom_range(2) == 0)
                  {r.arg_byte, r.sub_byte} = STEP_Z_LIMIT - 16'd20 + 16'($urandom_range(40));
               else if ($urandom_range(3) == 0)
                  {r.arg_byte, r.sub_byte} = '0;
            end
            10, 11, 12: begin
               r.cmd_byte = CMD_MOVE;
               if ($urandom_range(9) != 0)
                  r.sub_byte = ($urandom_range(1) == 0) ? SUB_MOVE_XYZ : SUB_MOVE_STEP;
            end
            default: ;
         endcase
      end else if (pick < 72) begin
         r.mode = MODE_MOVE_DONE;
      end else if (pick < 78) begin
         r.mode    = MODE_LINK;
         r.link_up = ($urandom_range(4) != 0);
      end else if (pick < 88) begin
         r.mode = MODE_SET_XYZ;
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(2))
               0: r.pos_x = '0;
               1: r.pos_x = HOME_X_MID;
               default: r.pos_x = HOME_X_FAR;
            endcase
            r.pos_y = '0;
            r.pos_z = '0;
         end
      end else if (pick < 95) begin
         r.mode = MODE_LATERAL;
      end else begin
         r.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------------------
   // Valid is only dropped when an idle gap is taken, so back-to-back requests
   // never see a low and a high scheduled in the same step.
   task automatic send_request(input req_type r);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] sub,
                             input logic [7:0] arg);
      req_type r;
      r          = blank_request(MODE_FRAME);
      r.cmd_byte = cmd;
      r.sub_byte = sub;
      r.arg_byte = arg;
      send_request(r);
   endtask

   // Stop sending and let every outstanding reply drain, plus pipeline slack
   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_replies.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers; call only while the block is idle
   task automatic load_config(input logic [15:0] needle, input logic [15:0] shuttle);
      csr_index <= CSR_NEEDLE;
      csr_data  <= needle;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      needle_reg = needle;
      csr_index <= CSR_SHUTTLE;
      csr_data  <= shuttle;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      shuttle_reg = shuttle;
      csr_valid <= 1'b0;
      config_writes += 2;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // Each command code but SET_Y, the status clear, busy/offline replies, the step-down clamp
   // and creep, home detection and reconnect behavior.
   task automatic test_directed_frames();
      req_type r;
      send_idle_pct = 0;
      stall_pct     = 0;
      load_config(16'hFFFF, 16'h0000);
      send_frame(CMD_SYSTEM, SUB_STATUS, 8'h00);          // offline: zeros
      r = blank_request(MODE_LINK);
      r.link_up = 1'b1;
      send_request(r);
      send_frame(CMD_SYSTEM, SUB_STATUS_CLR, ARG_CLEAR);  // reply, then clear top bits
      send_frame(CMD_SYSTEM, SUB_STATUS, 8'hFF);
      send_frame(CMD_SYSTEM, SUB_REVISION, 8'h00);
      send_frame(CMD_SYSTEM, SUB_CHECKSUM, 8'h00);
      send_frame(CMD_SYSTEM, SUB_NEEDLE, 8'h00);
      send_frame(CMD_SYSTEM, 8'hFF, 8'hFF);                // unknown subcommand
      send_frame(CMD_SET_X, 8'hFF, 8'hFF);
      send_frame(CMD_GET_X, SUB_TARGET, 8'h00);
      send_frame(CMD_GET_Z, SUB_SHUTTLE, 8'h00);
      send_frame(CMD_GET_Y, SUB_SHUTTLE, 8'h00);          // shuttle only on Z
      send_frame(CMD_SET_Z, 8'hFF, 8'hFF);
      send_frame(CMD_MOVE, SUB_MOVE_STEP, 8'h00);
      send_frame(CMD_GET_X, SUB_POSITION, 8'h00);         // busy: zeros
      send_request(blank_request(MODE_MOVE_DONE));        // Z clamps to limit
      send_frame(CMD_MOVE, SUB_MOVE_STEP, 8'h00);
      send_request(blank_request(MODE_MOVE_DONE));        // at limit: creeps by one step
      r = blank_request(MODE_SET_XYZ);
      r.pos_x = HOME_X_FAR;
      send_request(r);
      send_frame(CMD_MOVE, SUB_MOVE_XYZ, 8'h00);
      send_request(blank_request(MODE_MOVE_DONE));        // home flag
      r = blank_request(MODE_LATERAL);
      r.lateral = 2'b11;
      send_request(r);
      send_request(blank_request(MODE_SPARE_LAST));
      send_frame(8'hFF, 8'h00, 8'h00);                    // unknown command
      send_frame(CMD_MOVE, SUB_MOVE_XYZ, 8'h00);
      send_request(blank_request(MODE_LINK));             // link down, move pending
      send_request(blank_request(MODE_MOVE_DONE));        // ignored while offline
      r = blank_request(MODE_LINK);
      r.link_up = 1'b1;
      send_request(r);                                    // reconnect keeps the pending move
      send_request(blank_request(MODE_MOVE_DONE));
      wait_idle();
   endtask

   // Register values read back through the needle and shuttle commands
   task automatic test_config_registers();
      logic [15:0] needle_vals [4];
      logic [15:0] shuttle_vals [4];
      int          k;
      needle_vals  = '{16'h0000, 16'hFFFF, 16'h8001, 16'($urandom)};
      shuttle_vals = '{16'hFFFF, 16'h0000, 16'h7FFE, 16'($urandom)};
      for (k = 0; k < 4; k++) begin
         wait_idle();
         load_config(needle_vals[k], shuttle_vals[k]);
         send_frame(CMD_SYSTEM, SUB_NEEDLE, 8'h00);
         send_frame(CMD_GET_Z, SUB_SHUTTLE, 8'h00);
      end
      wait_idle();
   endtask

   // Random traffic under each idle/stall mix, fresh register values per phase
   task automatic test_random_traffic();
      int idle_mix [4];
      int stall_mix [4];
      int p;
      int n;
      idle_mix  = '{0, 68, 0, 22};
      stall_mix = '{0, 0, 68, 22};
      for (p = 0; p < 4; p++) begin
         wait_idle();
         load_config(16'($urandom), 16'($urandom));
         send_idle_pct = idle_mix[p];
         stall_pct     = stall_mix[p];
         for (n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request());
      end
      wait_idle();
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // pipe fills and req_ready drops; then the sender waits for a full drain.
   task automatic test_backpressure();
      int n;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests++;
      for (n = 0; n < 40; n++)
         send_request(random_request());
      wait_idle();
      stall_pct = 68;
      hold_requests++;
      for (n = 0; n < 20; n++)
         send_request(random_request());
      wait_idle();
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin : run_regression
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_config_registers();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("covered %0d requests over scripted, register, random and hold-off traffic",
               request_count);
      $display("%0d replies checked, %0d frames answered with data, %0d moves completed, %0d register writes",
               reply_count, frames_served, moves_finished, config_writes);
      if (mismatch_count == 0 && expected_replies.size() == 0)
         $display("positioner_command_responder regression: pass");
      else
         $display("positioner_command_responder regression: fail");
      $finish;
   end

endmodule

/* files.f */
sv/pcr_pkg.sv
sv/pcr_engine.sv
sv/positioner_command_responder.sv
verif/tb_positioner_command_responder.sv
